// ----- rtl/ggh_pkg.sv -----
package ggh_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int ATAN_IW          = $clog2(ATAN_LEN);
  localparam int QUEUE_DEPTH      = 2;
  localparam int PADDR_W          = 4;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_REACH_RADIUS      = 2'd0,
    REG_HEADING_TOLERANCE = 2'd1,
    REG_TURN_GAIN         = 2'd2,
    REG_FORWARD_SPEED     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_ODOM,
    KIND_GOAL,
    KIND_TICK
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
  } item_t;

  typedef struct packed {
    logic [15:0] reach_radius;
    logic [14:0] heading_tolerance;
    logic [15:0] turn_gain;
    logic [15:0] forward_speed;
  } cfg_t;

  // atan(2^-i) in Q16 radians, rounded to nearest
  function automatic logic [15:0] atan_q16(logic [ATAN_IW-1:0] i);
    logic [15:0] v;
    case (i)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30386;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/ggh_front.sv -----
module ggh_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_opcode,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_y,
  input  logic signed [15:0]  in_heading,
  output logic                in_stall,
  output logic                push_valid,
  output ggh_pkg::item_t      push_item,
  input  logic                push_ready
);

  localparam logic [1:0] OP_ODOM = 2'd0;
  localparam logic [1:0] OP_GOAL = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  logic           hold_valid_r, hold_valid_nxt;
  ggh_pkg::item_t hold_item_r, hold_item_nxt;
  logic           accept;
  logic           keep;

  assign in_stall   = hold_valid_r && !push_ready;
  assign accept     = in_valid && !in_stall;
  assign push_valid = hold_valid_r;
  assign push_item  = hold_item_r;

  always_comb begin
    keep                  = 1'b1;
    hold_item_nxt         = hold_item_r;
    hold_item_nxt.pos_x   = in_pos_x;
    hold_item_nxt.pos_y   = in_pos_y;
    hold_item_nxt.heading = in_heading;
    unique case (in_opcode)
      OP_ODOM: hold_item_nxt.kind = ggh_pkg::KIND_ODOM;
      OP_GOAL: hold_item_nxt.kind = ggh_pkg::KIND_GOAL;
      OP_TICK: hold_item_nxt.kind = ggh_pkg::KIND_TICK;
      OP_NONE: begin
        // unused opcode is swallowed here
        hold_item_nxt.kind = ggh_pkg::KIND_TICK;
        keep               = 1'b0;
      end
    endcase
    if (!accept) begin
      hold_item_nxt = hold_item_r;
    end
  end

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = keep;
    end else if (push_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_item_r <= hold_item_nxt;
  end

endmodule

// ----- rtl/ggh_queue.sv -----
module ggh_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  ggh_pkg::item_t push_item,
  output logic           push_ready,
  output logic           pop_valid,
  output ggh_pkg::item_t pop_item,
  input  logic           pop_ready
);

  localparam int DEPTH = ggh_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  ggh_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign push_ready = (count_r < CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

  a_both_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && do_pop) |=> $stable(count_r))
    else $error("queue count moved on simultaneous push and pop");

endmodule

// ----- rtl/ggh_back.sv -----
module ggh_back #(
  parameter int CORDIC_STEPS = ggh_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ggh_pkg::cfg_t       cfg,
  input  logic                q_valid,
  input  ggh_pkg::item_t      q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_linear_speed,
  output logic signed [15:0]  out_angular_rate,
  output logic                out_goal_reached
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int XW     = 36;
  localparam int ZW     = 20;
  localparam logic signed [ZW-1:0] Z_HALF_PI = ZW'(2 * 51472);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQX, S_SQY, S_SQR, S_CMP,
    S_PRE, S_ROT, S_ERR, S_MUL, S_RATE, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   pose_seen_r, pose_seen_nxt;
  logic   armed_r, armed_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic signed [31:0]    cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [15:0]    ch_r, ch_nxt;
  logic signed [31:0]    tx_r, tx_nxt, ty_r, ty_nxt;
  logic signed [32:0]    dx_r, dx_nxt, dy_r, dy_nxt;
  logic                  near_r, near_nxt;
  logic signed [35:0]    prod_r, prod_nxt;
  logic [32:0]           sum_r, sum_nxt;
  logic signed [XW-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0]  z_r, z_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic signed [17:0]    err_r, err_nxt;
  logic [15:0]           res_lin_r, res_lin_nxt;
  logic signed [15:0]    res_ang_r, res_ang_nxt;
  logic                  res_reached_r, res_reached_nxt;
  logic [15:0]           out_lin_r, out_lin_nxt;
  logic signed [15:0]    out_ang_r, out_ang_nxt;
  logic                  out_reached_r, out_reached_nxt;

  logic signed [18:0]    mul_a;
  logic signed [16:0]    mul_b;
  logic signed [35:0]    mul_p;
  logic signed [XW-1:0]  dx_w, dy_w, xs, ys;
  logic [15:0]           atan_v;
  logic signed [ZW-1:0]  z_rnd;
  logic signed [16:0]    bearing;
  logic signed [17:0]    tol_s;
  logic signed [35:0]    rate_sum;
  logic signed [23:0]    rate_sh;
  logic                  out_free;

  assign out_valid        = out_valid_r;
  assign out_linear_speed = out_lin_r;
  assign out_angular_rate = out_ang_r;
  assign out_goal_reached = out_reached_r;
  assign q_pop            = (state_r == S_IDLE) && q_valid;
  assign out_free         = !out_valid_r || !out_stall;

  // shared multiplier: squares of the offsets, squared radius, gain times error
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQX: begin
        mul_a = {{2{dx_r[16]}}, dx_r[16:0]};
        mul_b = dx_r[16:0];
      end
      S_SQY: begin
        mul_a = {{2{dy_r[16]}}, dy_r[16:0]};
        mul_b = dy_r[16:0];
      end
      S_SQR: begin
        mul_a = {3'b000, cfg.reach_radius};
        mul_b = {1'b0, cfg.reach_radius};
      end
      S_MUL: begin
        mul_a = {err_r[17], err_r};
        mul_b = {1'b0, cfg.turn_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign dx_w     = {{(XW-33){dx_r[32]}}, dx_r};
  assign dy_w     = {{(XW-33){dy_r[32]}}, dy_r};
  assign xs       = x_r >>> step_r;
  assign ys       = y_r >>> step_r;
  assign atan_v   = ggh_pkg::atan_q16(ggh_pkg::ATAN_IW'(step_r));
  assign z_rnd    = z_r + ZW'(4);
  assign bearing  = z_rnd[ZW-1:3];
  assign tol_s    = {3'b000, cfg.heading_tolerance};
  assign rate_sum = prod_r + 36'sd2048;
  assign rate_sh  = rate_sum[35:12];

  always_comb begin
    state_nxt       = state_r;
    pose_seen_nxt   = pose_seen_r;
    armed_nxt       = armed_r;
    out_valid_nxt   = out_valid_r && out_stall;
    cx_nxt          = cx_r;
    cy_nxt          = cy_r;
    ch_nxt          = ch_r;
    tx_nxt          = tx_r;
    ty_nxt          = ty_r;
    dx_nxt          = dx_r;
    dy_nxt          = dy_r;
    near_nxt        = near_r;
    prod_nxt        = prod_r;
    sum_nxt         = sum_r;
    x_nxt           = x_r;
    y_nxt           = y_r;
    z_nxt           = z_r;
    step_nxt        = step_r;
    err_nxt         = err_r;
    res_lin_nxt     = res_lin_r;
    res_ang_nxt     = res_ang_r;
    res_reached_nxt = res_reached_r;
    out_lin_nxt     = out_lin_r;
    out_ang_nxt     = out_ang_r;
    out_reached_nxt = out_reached_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_item.kind)
            ggh_pkg::KIND_ODOM: begin
              cx_nxt        = q_item.pos_x;
              cy_nxt        = q_item.pos_y;
              ch_nxt        = q_item.heading;
              pose_seen_nxt = 1'b1;
            end
            ggh_pkg::KIND_GOAL: begin
              tx_nxt    = q_item.pos_x;
              ty_nxt    = q_item.pos_y;
              armed_nxt = 1'b1;
            end
            ggh_pkg::KIND_TICK: begin
              if (pose_seen_r && armed_r) begin
                state_nxt = S_DIFF;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIFF: begin
        dx_nxt    = 33'(tx_r) - 33'(cx_r);
        dy_nxt    = 33'(ty_r) - 33'(cy_r);
        state_nxt = S_SQX;
      end
      S_SQX: begin
        near_nxt  = (dx_r > -33'sd65536) && (dx_r < 33'sd65536) &&
                    (dy_r > -33'sd65536) && (dy_r < 33'sd65536);
        prod_nxt  = mul_p;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        sum_nxt   = {1'b0, prod_r[31:0]};
        prod_nxt  = mul_p;
        state_nxt = S_SQR;
      end
      S_SQR: begin
        sum_nxt   = sum_r + {1'b0, prod_r[31:0]};
        prod_nxt  = mul_p;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (near_r && (sum_r < {1'b0, prod_r[31:0]})) begin
          armed_nxt       = 1'b0;
          res_lin_nxt     = '0;
          res_ang_nxt     = '0;
          res_reached_nxt = 1'b1;
          state_nxt       = S_EMIT;
        end else begin
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        step_nxt = '0;
        if (dx_r == '0 && dy_r == '0) begin
          // zero vector has bearing zero
          z_nxt     = '0;
          state_nxt = S_ERR;
        end else begin
          state_nxt = S_ROT;
          if (dx_r < 0) begin
            if (dy_r >= 0) begin
              z_nxt = Z_HALF_PI;
              x_nxt = dy_w;
              y_nxt = -dx_w;
            end else begin
              z_nxt = -Z_HALF_PI;
              x_nxt = -dy_w;
              y_nxt = dx_w;
            end
          end else begin
            z_nxt = '0;
            x_nxt = dx_w;
            y_nxt = dy_w;
          end
        end
      end
      S_ROT: begin
        if (y_r >= 0) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + $signed({{(ZW-16){1'b0}}, atan_v});
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - $signed({{(ZW-16){1'b0}}, atan_v});
        end
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          state_nxt = S_ERR;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_ERR: begin
        err_nxt = {bearing[16], bearing} - {{2{ch_r[15]}}, ch_r};
        if ((err_nxt > tol_s) || (err_nxt < -tol_s)) begin
          state_nxt = S_MUL;
        end else begin
          res_lin_nxt     = cfg.forward_speed;
          res_ang_nxt     = '0;
          res_reached_nxt = 1'b0;
          state_nxt       = S_EMIT;
        end
      end
      S_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_RATE;
      end
      S_RATE: begin
        res_lin_nxt     = '0;
        res_reached_nxt = 1'b0;
        if (rate_sh > 24'sd32767) begin
          res_ang_nxt = 16'sh7fff;
        end else if (rate_sh < -24'sd32768) begin
          res_ang_nxt = -16'sh8000;
        end else begin
          res_ang_nxt = rate_sh[15:0];
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_lin_nxt     = res_lin_r;
          out_ang_nxt     = res_ang_r;
          out_reached_nxt = res_reached_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pose_seen_r <= 1'b0;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pose_seen_r <= pose_seen_nxt;
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cx_r          <= cx_nxt;
    cy_r          <= cy_nxt;
    ch_r          <= ch_nxt;
    tx_r          <= tx_nxt;
    ty_r          <= ty_nxt;
    dx_r          <= dx_nxt;
    dy_r          <= dy_nxt;
    near_r        <= near_nxt;
    prod_r        <= prod_nxt;
    sum_r         <= sum_nxt;
    x_r           <= x_nxt;
    y_r           <= y_nxt;
    z_r           <= z_nxt;
    step_r        <= step_nxt;
    err_r         <= err_nxt;
    res_lin_r     <= res_lin_nxt;
    res_ang_r     <= res_ang_nxt;
    res_reached_r <= res_reached_nxt;
    out_lin_r     <= out_lin_nxt;
    out_ang_r     <= out_ang_nxt;
    out_reached_r <= out_reached_nxt;
  end

  a_stop_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_reached_r) |-> (out_lin_r == '0 && out_ang_r == '0))
    else $error("arrival stop carries a nonzero speed");

  a_drive_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_lin_r != '0) |-> (out_ang_r == '0 && !out_reached_r))
    else $error("straight drive carries a turn or arrival");

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EMIT)
    else $error("result raised outside the emit step");

endmodule

// ----- rtl/go_to_goal_heading_controller.sv -----
// go-to-goal heading controller
// input channel (in_valid / in_stall): opcode 0 sets the pose, 1 sets and arms
// a goal, 2 asks for one drive command, 3 is dropped. a transaction completes
// at a clock edge with in_valid high and in_stall low.
// result channel (out_valid / out_stall): one command per tick once a pose has
// been seen and a goal is armed; it holds until taken, and the next command
// waits for it while further items keep queueing.
// items pass a one-entry input register and a two-entry queue before the
// executing side; in_stall rises only when both are full.
// the executing side takes one item at a time: pose and goal items are
// stored from idle; a tick forms the offsets, squares them and the radius
// and compares; a tick that reaches the goal emits a stop, else the
// iterative CORDIC, one rotation per cycle, gives the bearing, the heading
// error is held to the tolerance and a turn also takes the gain multiply.
// apb port (psel ... pready) writes and reads the four tuning registers at
// 0x0, 0x4, 0x8, 0xc; pready is tied high. write only while idle.
// reset (rst_n low, synchronous) restores the register defaults, forgets the
// pose and the goal and empties the queue.
module go_to_goal_heading_controller #(
  parameter int CORDIC_STEPS = ggh_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic signed [31:0]            in_pos_x,
  input  logic signed [31:0]            in_pos_y,
  input  logic signed [15:0]            in_heading,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_linear_speed,
  output logic signed [15:0]            out_angular_rate,
  output logic                          out_goal_reached,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ggh_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  ggh_pkg::cfg_t     cfg_r, cfg_nxt;
  ggh_pkg::reg_idx_t reg_idx;
  logic              cfg_we;
  logic              push_valid, push_ready;
  ggh_pkg::item_t    push_item;
  logic              q_valid, q_pop;
  ggh_pkg::item_t    q_item;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = ggh_pkg::reg_idx_t'(paddr[3:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx)
        ggh_pkg::REG_REACH_RADIUS:      cfg_nxt.reach_radius      = pwdata[15:0];
        ggh_pkg::REG_HEADING_TOLERANCE: cfg_nxt.heading_tolerance = pwdata[14:0];
        ggh_pkg::REG_TURN_GAIN:         cfg_nxt.turn_gain         = pwdata[15:0];
        ggh_pkg::REG_FORWARD_SPEED:     cfg_nxt.forward_speed     = pwdata[15:0];
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ggh_pkg::REG_REACH_RADIUS:      prdata = {16'h0000, cfg_r.reach_radius};
      ggh_pkg::REG_HEADING_TOLERANCE: prdata = {17'h00000, cfg_r.heading_tolerance};
      ggh_pkg::REG_TURN_GAIN:         prdata = {16'h0000, cfg_r.turn_gain};
      ggh_pkg::REG_FORWARD_SPEED:     prdata = {16'h0000, cfg_r.forward_speed};
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reach_radius      <= 16'd6554;
      cfg_r.heading_tolerance <= 15'd819;
      cfg_r.turn_gain         <= 16'd2048;
      cfg_r.forward_speed     <= 16'd13107;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ggh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_opcode  (in_opcode),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_heading (in_heading),
    .in_stall   (in_stall),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  ggh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop_ready  (q_pop)
  );

  ggh_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_linear_speed (out_linear_speed),
    .out_angular_rate (out_angular_rate),
    .out_goal_reached (out_goal_reached)
  );

endmodule
